// ===== sv/lobm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and helpers for the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

   // Sequencer states of the matcher.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MATCH_RD,
      ST_MATCH_CHK,
      ST_POP_RD,
      ST_POP_CHK,
      ST_SD_RD,
      ST_SD_CMP,
      ST_REST,
      ST_SU_RD,
      ST_SU_CMP,
      ST_RESP
   } state_type;

   // Book side codes.
   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   // Width and maximum of the reported backlog total.
   localparam int unsigned TOTAL_OUT_BITS = 48;
   localparam logic [63:0] TOTAL_OUT_MAX  = 64'h0000_FFFF_FFFF_FFFF;

   // True if entry a has priority over entry b in the book of the given side.
   // The buy book serves the highest price first, the sell book the lowest;
   // at equal price the larger amount goes first.
   function automatic logic outranks(logic side, logic [31:0] pa, logic [31:0] aa,
                                     logic [31:0] pb, logic [31:0] ab);
      if (pa != pb) begin
         return (side == SIDE_SELL) ? (pa < pb) : (pa > pb);
      end
      return aa > ab;
   endfunction

endpackage

// ===== sv/lobm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_ram
// Generic synchronous RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module lobm_ram #(
   parameter int unsigned WIDTH = 60,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ===== sv/limit_order_book_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-priority order book with buy and sell heaps held in on-chip RAM.
// ----------------------------------------------------------------------------
// One order is taken per beat and one result beat is returned per order. Each
// book is a binary heap in its own RAM, walked by a single sequencer. An order
// is taken in, its remainder is decided on and its result is handed off. Each
// match reads and checks the top entry, fetches the last entry when that entry
// is used up, then sifts the entry down level by level through the heap and
// places it; the look at the opposite book that ends matching comes last. A
// remainder that rests is sifted up level by level and then placed. The heap
// walks through the RAM ports set the rate. A new order is accepted while the
// previous result beat still waits on the response channel. No clearing pass
// is needed after reset; the entry counts bound every heap access.
// ----------------------------------------------------------------------------
module limit_order_book_matcher #(
   parameter int unsigned BOOK_DEPTH  = 1024,
   parameter int unsigned PRICE_BITS  = 30,
   parameter int unsigned AMOUNT_BITS = 30
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PRICE_BITS-1:0]  req_order_price,
   input  logic [AMOUNT_BITS-1:0] req_order_amount,
   input  logic                   req_order_side,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [29:0]            rsp_filled_amount,
   output logic [10:0]            rsp_buy_entries,
   output logic [10:0]            rsp_sell_entries,
   output logic [47:0]            rsp_backlog_total,
   output logic                   rsp_book_full_drop
);

   localparam int unsigned IDX_W = $clog2(BOOK_DEPTH);
   localparam int unsigned CNT_W = $clog2(BOOK_DEPTH + 1);
   localparam int unsigned POS_W = IDX_W + 2;
   localparam int unsigned E_W   = PRICE_BITS + AMOUNT_BITS;
   localparam int unsigned TOT_W = AMOUNT_BITS + CNT_W;

   lobm_pkg::state_type state_ff, state_in;

   logic [PRICE_BITS-1:0]  price_ff, price_in;
   logic [AMOUNT_BITS-1:0] amt_ff, amt_in;
   logic                   side_ff, side_in;
   logic [AMOUNT_BITS-1:0] filled_ff, filled_in;
   logic                   drop_ff, drop_in;
   logic                   sel_ff, sel_in;
   logic [E_W-1:0]         cur_ff, cur_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       cnt_ff [2];
   logic [CNT_W-1:0]       cnt_in [2];
   logic [TOT_W-1:0]       total_ff, total_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [29:0]            rsp_filled_ff, rsp_filled_in;
   logic [10:0]            rsp_buy_ff, rsp_buy_in;
   logic [10:0]            rsp_sell_ff, rsp_sell_in;
   logic [47:0]            rsp_total_ff, rsp_total_in;
   logic                   rsp_drop_ff, rsp_drop_in;

   // RAM ports, shared by both books; the write enable picks the book.
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [E_W-1:0]         wr_data;
   logic [IDX_W-1:0]       rd_addr_a, rd_addr_b;
   logic [E_W-1:0]         buy_rd_a, buy_rd_b, sell_rd_a, sell_rd_b;
   logic [E_W-1:0]         rd_a, rd_b;

   lobm_ram #(.WIDTH(E_W), .DEPTH(BOOK_DEPTH)) u_buy_ram (
      .clock     (clock),
      .wr_en     (wr_en && (sel_ff == lobm_pkg::SIDE_BUY)),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (buy_rd_a),
      .rd_data_b (buy_rd_b)
   );

   lobm_ram #(.WIDTH(E_W), .DEPTH(BOOK_DEPTH)) u_sell_ram (
      .clock     (clock),
      .wr_en     (wr_en && (sel_ff == lobm_pkg::SIDE_SELL)),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (sell_rd_a),
      .rd_data_b (sell_rd_b)
   );

   assign rd_a = (sel_ff == lobm_pkg::SIDE_SELL) ? sell_rd_a : buy_rd_a;
   assign rd_b = (sel_ff == lobm_pkg::SIDE_SELL) ? sell_rd_b : buy_rd_b;

   // Field views of the read data and the held entry.
   logic [PRICE_BITS-1:0]  a_price, b_price, cur_price;
   logic [AMOUNT_BITS-1:0] a_amt, b_amt, cur_amt;
   assign a_price   = rd_a[E_W-1:AMOUNT_BITS];
   assign a_amt     = rd_a[AMOUNT_BITS-1:0];
   assign b_price   = rd_b[E_W-1:AMOUNT_BITS];
   assign b_amt     = rd_b[AMOUNT_BITS-1:0];
   assign cur_price = cur_ff[E_W-1:AMOUNT_BITS];
   assign cur_amt   = cur_ff[AMOUNT_BITS-1:0];

   // Heap positions around the current hole.
   logic [POS_W-1:0] pos_l, pos_r, pos_n;
   logic [IDX_W-1:0] pos_p;
   assign pos_l = {1'b0, idx_ff, 1'b1};
   assign pos_r = pos_l + POS_W'(1);
   assign pos_n = POS_W'(cnt_ff[sel_ff]);
   assign pos_p = IDX_W'((idx_ff - IDX_W'(1)) >> 1);

   // Comparisons used by matching and both sift directions.
   logic crosses, take_l, take_r, cur_up;
   logic [E_W-1:0] best_l;
   assign crosses = (side_ff == lobm_pkg::SIDE_SELL) ? (a_price >= price_ff)
                                                     : (a_price <= price_ff);
   assign take_l  = lobm_pkg::outranks(sel_ff, 32'(a_price), 32'(a_amt),
                                       32'(cur_price), 32'(cur_amt));
   assign best_l  = take_l ? rd_a : cur_ff;
   assign take_r  = (pos_r < pos_n) &&
                    lobm_pkg::outranks(sel_ff, 32'(b_price), 32'(b_amt),
                                       32'(best_l[E_W-1:AMOUNT_BITS]),
                                       32'(best_l[AMOUNT_BITS-1:0]));
   assign cur_up  = lobm_pkg::outranks(side_ff, 32'(cur_price), 32'(cur_amt),
                                       32'(a_price), 32'(a_amt));

   // Saturated view of the exact resting total.
   logic [63:0] total_wide;
   logic [47:0] total_sat;
   assign total_wide = 64'(total_ff);
   assign total_sat  = (total_wide > lobm_pkg::TOTAL_OUT_MAX)
                       ? lobm_pkg::TOTAL_OUT_BITS'(lobm_pkg::TOTAL_OUT_MAX)
                       : total_wide[47:0];

   // Sequencer: match against the opposite book, then rest the remainder.
   always_comb begin
      state_in      = state_ff;
      price_in      = price_ff;
      amt_in        = amt_ff;
      side_in       = side_ff;
      filled_in     = filled_ff;
      drop_in       = drop_ff;
      sel_in        = sel_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      cnt_in[0]     = cnt_ff[0];
      cnt_in[1]     = cnt_ff[1];
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_filled_in = rsp_filled_ff;
      rsp_buy_in    = rsp_buy_ff;
      rsp_sell_in   = rsp_sell_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_drop_in   = rsp_drop_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = cur_ff;
      rd_addr_a     = '0;
      rd_addr_b     = '0;
      unique case (state_ff)
         lobm_pkg::ST_IDLE: begin
            if (req_valid) begin
               price_in  = req_order_price;
               amt_in    = req_order_amount;
               side_in   = req_order_side;
               sel_in    = ~req_order_side;
               filled_in = '0;
               drop_in   = 1'b0;
               state_in  = lobm_pkg::ST_MATCH_RD;
            end
         end
         lobm_pkg::ST_MATCH_RD: begin
            if ((amt_ff == '0) || (cnt_ff[sel_ff] == '0)) begin
               sel_in   = side_ff;
               state_in = lobm_pkg::ST_REST;
            end else begin
               rd_addr_a = '0;
               state_in  = lobm_pkg::ST_MATCH_CHK;
            end
         end
         lobm_pkg::ST_MATCH_CHK: begin
            if (!crosses) begin
               sel_in   = side_ff;
               state_in = lobm_pkg::ST_REST;
            end else if (a_amt <= amt_ff) begin
               // The top entry is used up and leaves the book.
               amt_in         = amt_ff - a_amt;
               filled_in      = filled_ff + a_amt;
               total_in       = total_ff - TOT_W'(a_amt);
               cnt_in[sel_ff] = cnt_ff[sel_ff] - CNT_W'(1);
               state_in       = lobm_pkg::ST_POP_RD;
            end else begin
               // The top entry is trimmed and sifted back into place.
               cur_in    = {a_price, a_amt - amt_ff};
               filled_in = filled_ff + amt_ff;
               total_in  = total_ff - TOT_W'(amt_ff);
               amt_in    = '0;
               idx_in    = '0;
               state_in  = lobm_pkg::ST_SD_RD;
            end
         end
         lobm_pkg::ST_POP_RD: begin
            if (cnt_ff[sel_ff] == '0) begin
               state_in = lobm_pkg::ST_MATCH_RD;
            end else begin
               rd_addr_a = cnt_ff[sel_ff][IDX_W-1:0];
               state_in  = lobm_pkg::ST_POP_CHK;
            end
         end
         lobm_pkg::ST_POP_CHK: begin
            cur_in   = rd_a;
            idx_in   = '0;
            state_in = lobm_pkg::ST_SD_RD;
         end
         lobm_pkg::ST_SD_RD: begin
            if (pos_l >= pos_n) begin
               wr_en    = 1'b1;
               state_in = lobm_pkg::ST_MATCH_RD;
            end else begin
               rd_addr_a = pos_l[IDX_W-1:0];
               rd_addr_b = pos_r[IDX_W-1:0];
               state_in  = lobm_pkg::ST_SD_CMP;
            end
         end
         lobm_pkg::ST_SD_CMP: begin
            wr_en = 1'b1;
            if (take_r) begin
               wr_data  = rd_b;
               idx_in   = pos_r[IDX_W-1:0];
               state_in = lobm_pkg::ST_SD_RD;
            end else if (take_l) begin
               wr_data  = rd_a;
               idx_in   = pos_l[IDX_W-1:0];
               state_in = lobm_pkg::ST_SD_RD;
            end else begin
               state_in = lobm_pkg::ST_MATCH_RD;
            end
         end
         lobm_pkg::ST_REST: begin
            if (amt_ff == '0) begin
               state_in = lobm_pkg::ST_RESP;
            end else if (cnt_ff[side_ff] >= CNT_W'(BOOK_DEPTH)) begin
               drop_in  = 1'b1;
               state_in = lobm_pkg::ST_RESP;
            end else begin
               cur_in   = {price_ff, amt_ff};
               idx_in   = cnt_ff[side_ff][IDX_W-1:0];
               state_in = lobm_pkg::ST_SU_RD;
            end
         end
         lobm_pkg::ST_SU_RD: begin
            if (idx_ff == '0) begin
               wr_en           = 1'b1;
               cnt_in[side_ff] = cnt_ff[side_ff] + CNT_W'(1);
               total_in        = total_ff + TOT_W'(amt_ff);
               state_in        = lobm_pkg::ST_RESP;
            end else begin
               rd_addr_a = pos_p;
               state_in  = lobm_pkg::ST_SU_CMP;
            end
         end
         lobm_pkg::ST_SU_CMP: begin
            wr_en = 1'b1;
            if (cur_up) begin
               wr_data  = rd_a;
               idx_in   = pos_p;
               state_in = lobm_pkg::ST_SU_RD;
            end else begin
               cnt_in[side_ff] = cnt_ff[side_ff] + CNT_W'(1);
               total_in        = total_ff + TOT_W'(amt_ff);
               state_in        = lobm_pkg::ST_RESP;
            end
         end
         lobm_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_filled_in = 30'(filled_ff);
               rsp_buy_in    = 11'(cnt_ff[0]);
               rsp_sell_in   = 11'(cnt_ff[1]);
               rsp_total_in  = total_sat;
               rsp_drop_in   = drop_ff;
               state_in      = lobm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lobm_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lobm_pkg::ST_IDLE;
         cnt_ff[0]    <= '0;
         cnt_ff[1]    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff[0]    <= cnt_in[0];
         cnt_ff[1]    <= cnt_in[1];
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload.
   always_ff @(posedge clock) begin
      price_ff      <= price_in;
      amt_ff        <= amt_in;
      side_ff       <= side_in;
      filled_ff     <= filled_in;
      drop_ff       <= drop_in;
      sel_ff        <= sel_in;
      cur_ff        <= cur_in;
      idx_ff        <= idx_in;
      rsp_filled_ff <= rsp_filled_in;
      rsp_buy_ff    <= rsp_buy_in;
      rsp_sell_ff   <= rsp_sell_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   assign req_stall          = (state_ff != lobm_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filled_amount  = rsp_filled_ff;
   assign rsp_buy_entries    = rsp_buy_ff;
   assign rsp_sell_entries   = rsp_sell_ff;
   assign rsp_backlog_total  = rsp_total_ff;
   assign rsp_book_full_drop = rsp_drop_ff;

`ifndef SYNTH
   // Neither book ever holds more entries than it has room for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff[0] <= CNT_W'(BOOK_DEPTH)) && (cnt_ff[1] <= CNT_W'(BOOK_DEPTH)))
      else $error("book entry count beyond depth");

   // Empty books hold no resting amount.
   a_total_empty: assert property (@(posedge clock) disable iff (reset)
      ((cnt_ff[0] == '0) && (cnt_ff[1] == '0)) |-> (total_ff == '0))
      else $error("resting total nonzero with both books empty");

   // Sift-down only walks the opposite book, sift-up only the own book.
   a_sift_book: assert property (@(posedge clock) disable iff (reset)
      ((state_ff != lobm_pkg::ST_SD_CMP) || (sel_ff != side_ff)) &&
      ((state_ff != lobm_pkg::ST_SU_CMP) || (sel_ff == side_ff)))
      else $error("heap walk on the wrong book");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the limit order book matcher.
// ----------------------------------------------------------------------------
// A short table of directed orders comes first. Rows with obvious outcomes
// carry typed expectations, and the other rows use the bench's own book
// model. Random orders then mix small crossing orders near one price band
// with full-range noise. A final stretch fills the buy book until orders are
// dropped, then sweeps it. Both sides idle at random, with some stretches
// in which they do not idle.
// ----------------------------------------------------------------------------
module tb;

   localparam int DEPTH = 1024;

   typedef struct packed {
      logic [29:0] filled;
      logic [10:0] buys;
      logic [10:0] sells;
      logic [47:0] total;
      logic        drop;
   } fill_report_type;

   typedef struct {
      logic [29:0]     price;
      logic [29:0]     amount;
      logic            side;
      bit              typed;
      fill_report_type want;
   } order_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [29:0] req_order_price = '0;
   logic [29:0] req_order_amount = '0;
   logic        req_order_side = lobm_pkg::SIDE_BUY;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [29:0] rsp_filled_amount;
   logic [10:0] rsp_buy_entries;
   logic [10:0] rsp_sell_entries;
   logic [47:0] rsp_backlog_total;
   logic        rsp_book_full_drop;

   // Model of both books: index 0 is the buy book, 1 the sell book.
   logic [29:0] book_price [2][DEPTH];
   logic [29:0] book_amount[2][DEPTH];
   int          book_n[2];
   logic [63:0] resting_sum;

   fill_report_type pending_reports[$];
   int              errors = 0;
   int              orders_sent = 0;
   int              reports_seen = 0;
   int              rsp_wait = 0;

   limit_order_book_matcher u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_order_price(req_order_price), .req_order_amount(req_order_amount),
      .req_order_side(req_order_side),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_filled_amount(rsp_filled_amount), .rsp_buy_entries(rsp_buy_entries),
      .rsp_sell_entries(rsp_sell_entries), .rsp_backlog_total(rsp_backlog_total),
      .rsp_book_full_drop(rsp_book_full_drop)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // True if entry i ranks ahead of entry j in book sd.
   function automatic bit ranks_ahead(int sd, int i, int j);
      if (book_price[sd][i] != book_price[sd][j]) begin
         return (sd == lobm_pkg::SIDE_BUY) ? (book_price[sd][i] > book_price[sd][j])
                                           : (book_price[sd][i] < book_price[sd][j]);
      end
      return book_amount[sd][i] > book_amount[sd][j];
   endfunction

   function automatic void swap_entries(int sd, int i, int j);
      logic [29:0] p;
      logic [29:0] a;
      p = book_price[sd][i];
      a = book_amount[sd][i];
      book_price[sd][i] = book_price[sd][j];
      book_amount[sd][i] = book_amount[sd][j];
      book_price[sd][j] = p;
      book_amount[sd][j] = a;
   endfunction

   function automatic void settle_down(int sd);
      int i;
      int best;
      i = 0;
      forever begin
         best = i;
         if (2 * i + 1 < book_n[sd] && ranks_ahead(sd, 2 * i + 1, best)) best = 2 * i + 1;
         if (2 * i + 2 < book_n[sd] && ranks_ahead(sd, 2 * i + 2, best)) best = 2 * i + 2;
         if (best == i) break;
         swap_entries(sd, i, best);
         i = best;
      end
   endfunction

   function automatic void settle_up(int sd, int start);
      int i;
      i = start;
      while (i > 0 && ranks_ahead(sd, i, (i - 1) / 2)) begin
         swap_entries(sd, i, (i - 1) / 2);
         i = (i - 1) / 2;
      end
   endfunction

   // Run one order through the model books and return its report.
   function automatic fill_report_type match_order(logic [29:0] p, logic [29:0] a, logic s);
      fill_report_type r;
      logic [63:0]     left;
      logic [63:0]     filled;
      int              opp;
      int              own;
      bit              crosses;
      left = 64'(a);
      filled = '0;
      own = int'(s);
      opp = 1 - own;
      r.drop = 1'b0;
      while (left > 0 && book_n[opp] > 0) begin
         crosses = (s == lobm_pkg::SIDE_BUY) ? (book_price[opp][0] <= p)
                                             : (book_price[opp][0] >= p);
         if (!crosses) break;
         if (book_amount[opp][0] <= left) begin
            left -= 64'(book_amount[opp][0]);
            filled += 64'(book_amount[opp][0]);
            resting_sum -= 64'(book_amount[opp][0]);
            book_n[opp]--;
            book_price[opp][0] = book_price[opp][book_n[opp]];
            book_amount[opp][0] = book_amount[opp][book_n[opp]];
         end else begin
            book_amount[opp][0] -= left[29:0];
            filled += left;
            resting_sum -= left;
            left = '0;
         end
         settle_down(opp);
      end
      // Any remainder rests on its own side, or is dropped when that book is full.
      if (left > 0) begin
         if (book_n[own] >= DEPTH) begin
            r.drop = 1'b1;
         end else begin
            book_price[own][book_n[own]] = p;
            book_amount[own][book_n[own]] = left[29:0];
            settle_up(own, book_n[own]);
            book_n[own]++;
            resting_sum += left;
         end
      end
      r.filled = filled[29:0];
      r.buys = 11'(book_n[0]);
      r.sells = 11'(book_n[1]);
      r.total = (resting_sum > lobm_pkg::TOTAL_OUT_MAX) ? 48'(lobm_pkg::TOTAL_OUT_MAX)
                                                        : resting_sum[47:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on report %0d: %s got %0d, expected %0d",
               reports_seen, what, got, want);
      errors++;
   endtask

   // Offer one order beat after a random gap, then log its expected report.
   task automatic send_order(logic [29:0] p, logic [29:0] a, logic s, bit typed,
                             fill_report_type want);
      int              gap;
      fill_report_type r;
      gap = ((orders_sent / 64) % 4 != 3) ? int'($urandom_range(0, 13)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_order_price <= p;
      req_order_amount <= a;
      req_order_side <= s;
      do @(posedge clock); while (req_stall);
      r = match_order(p, a, s);
      pending_reports.push_back(typed ? want : r);
      orders_sent++;
   endtask

   // Result side: check each accepted beat and draw the next stall.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_wait > 0) rsp_wait--;
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               $display("unexpected report beat %0d", reports_seen);
               errors++;
            end else begin
               fill_report_type w;
               w = pending_reports.pop_front();
               if (rsp_filled_amount != w.filled)
                  report_mismatch("filled_amount", 64'(rsp_filled_amount), 64'(w.filled));
               if (rsp_buy_entries != w.buys)
                  report_mismatch("buy_entries", 64'(rsp_buy_entries), 64'(w.buys));
               if (rsp_sell_entries != w.sells)
                  report_mismatch("sell_entries", 64'(rsp_sell_entries), 64'(w.sells));
               if (rsp_backlog_total != w.total)
                  report_mismatch("backlog_total", 64'(rsp_backlog_total), 64'(w.total));
               if (rsp_book_full_drop != w.drop)
                  report_mismatch("book_full_drop", 64'(rsp_book_full_drop), 64'(w.drop));
            end
            reports_seen++;
            rsp_wait = ((reports_seen / 80) % 4 != 2) ? int'($urandom_range(0, 13)) : 0;
         end
         rsp_stall <= (rsp_wait > 0);
      end
   end

   // Directed orders; typed rows hold expectations that follow by hand.
   localparam logic [29:0] MAXV = 30'h3FFF_FFFF;
   order_row_type opening[] = '{
      '{30'd100, 30'd50, lobm_pkg::SIDE_BUY, 1, '{30'd0, 11'd1, 11'd0, 48'd50, 1'b0}},
      '{30'd200, 30'd30, lobm_pkg::SIDE_SELL, 1, '{30'd0, 11'd1, 11'd1, 48'd80, 1'b0}},
      '{30'd200, 30'd10, lobm_pkg::SIDE_BUY, 1, '{30'd10, 11'd1, 11'd1, 48'd70, 1'b0}},
      '{30'd150, 30'd0, lobm_pkg::SIDE_BUY, 1, '{30'd0, 11'd1, 11'd1, 48'd70, 1'b0}},
      '{30'd100, 30'd60, lobm_pkg::SIDE_SELL, 1, '{30'd50, 11'd0, 11'd2, 48'd30, 1'b0}},
      '{MAXV, MAXV, lobm_pkg::SIDE_BUY, 1,
        '{30'd30, 11'd1, 11'd0, 48'(MAXV - 30), 1'b0}},
      '{30'd1, MAXV, lobm_pkg::SIDE_SELL, 1,
        '{MAXV - 30'd30, 11'd0, 11'd1, 48'd30, 1'b0}},
      '{30'd0, 30'd0, lobm_pkg::SIDE_SELL, 1, '{30'd0, 11'd0, 11'd1, 48'd30, 1'b0}},
      '{30'd0, 30'd7, lobm_pkg::SIDE_BUY, 0, '0},
      '{30'd0, 30'd7, lobm_pkg::SIDE_SELL, 0, '0},
      '{30'd500, 30'd5, lobm_pkg::SIDE_SELL, 0, '0},
      '{30'd500, 30'd9, lobm_pkg::SIDE_SELL, 0, '0},
      '{30'd500, 30'd9, lobm_pkg::SIDE_SELL, 0, '0},
      '{30'd500, 30'd12, lobm_pkg::SIDE_BUY, 0, '0},
      '{30'd499, 30'd3, lobm_pkg::SIDE_BUY, 0, '0},
      '{30'd499, 30'd3, lobm_pkg::SIDE_BUY, 0, '0},
      '{30'd499, 30'd8, lobm_pkg::SIDE_BUY, 0, '0},
      '{30'd499, 30'd4, lobm_pkg::SIDE_SELL, 0, '0},
      '{MAXV, 30'd1, lobm_pkg::SIDE_SELL, 0, '0},
      '{30'd1, MAXV, lobm_pkg::SIDE_BUY, 0, '0},
      '{MAXV, MAXV, lobm_pkg::SIDE_BUY, 0, '0},
      '{30'd2, 30'd20, lobm_pkg::SIDE_SELL, 0, '0}
   };

   initial begin
      logic [29:0] p;
      logic [29:0] a;
      logic        s;
      book_n[0] = 0;
      book_n[1] = 0;
      resting_sum = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i])
         send_order(opening[i].price, opening[i].amount, opening[i].side,
                    opening[i].typed, opening[i].want);

      // Random mix: mostly small orders in one crossing band, some full-range noise.
      // The book-full stretch below needs a full book's worth of orders, so this
      // part stays short.
      repeat (200) begin
         s = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 9) < 8) begin
            p = 30'(500000 + $urandom_range(0, 2000) - 1000);
            a = 30'($urandom_range(1, 1000));
         end else begin
            p = 30'($urandom);
            a = ($urandom_range(0, 7) == 0) ? 30'd0 : 30'($urandom);
         end
         send_order(p, a, s, 0, '0);
      end

      // Fill the buy book with non-crossing bids until remainders are dropped.
      while (book_n[0] < DEPTH)
         send_order(30'($urandom_range(1, 1000)), 30'($urandom_range(1, 500)),
                    lobm_pkg::SIDE_BUY, 0, '0);
      repeat (6)
         send_order(30'($urandom_range(1, 1000)), 30'($urandom_range(1, 500)),
                    lobm_pkg::SIDE_BUY, 0, '0);
      send_order(30'd1, MAXV, lobm_pkg::SIDE_SELL, 0, '0);
      send_order(30'd10, 30'd5, lobm_pkg::SIDE_BUY, 0, '0);
      req_valid <= 1'b0;

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0 && pending_reports.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/lobm_pkg.sv
sv/lobm_ram.sv
sv/limit_order_book_matcher.sv
sim/tb.sv
